// ===== hw/rtl/datapoint_frame_status_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// datapoint frame status decoder assertion macros
// concurrent check helpers, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef DATAPOINT_FRAME_STATUS_DECODER_MACROS_SVH
`define DATAPOINT_FRAME_STATUS_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define DFSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen
`define DFSD_NEVER(lbl, cond, msg) \
	`DFSD_ASSERT(lbl, !(cond), msg)

`else

`define DFSD_ASSERT(lbl, prop, msg)
`define DFSD_NEVER(lbl, cond, msg)

`endif

`endif

// ===== hw/rtl/dfsd_pkg.sv =====
// ----------------------------------------------------------------------------
// dfsd_pkg
// shared types for the datapoint frame status decoder: record commands
// passed from the frame parser to the status register bank
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfsd_pkg;

	// status register targeted by a completed record
	typedef enum logic [3:0] {
		K_POWER = 4'd0,
		K_AUTO  = 4'd1,
		K_TIMER = 4'd2,
		K_MIST  = 4'd3,
		K_WARM  = 4'd4,
		K_GOAL  = 4'd5,
		K_SLEEP = 4'd6,
		K_TEMP  = 4'd7,
		K_HUM   = 4'd8
	} kind_t;

	// one validated record: target, new value, datapoint id
	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic [7:0]  id;
	} cmd_t;

	// queue status seen by the register bank and the input handshake
	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

	// result payload: 100 bits of fields padded to whole bytes
	localparam int unsigned OUT_W = 104;

endpackage

// ===== hw/rtl/dfsd_front.sv =====
// ----------------------------------------------------------------------------
// dfsd_front
// frame parser: hunts the header, walks the frame and datapoint records and
// turns every record that passes its id check into a register command
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfsd_front import dfsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	output logic       push,
	output cmd_t       push_cmd
);

	localparam logic [7:0] SYNC0    = 8'h55;
	localparam logic [7:0] SYNC1    = 8'hAA;
	localparam logic [7:0] VER_DP   = 8'h03;
	localparam logic [7:0] ID_POWER = 8'h01;
	localparam logic [7:0] ID_AUTO  = 8'h02;
	localparam logic [7:0] ID_TIMER = 8'h13;
	localparam logic [7:0] ID_MIST  = 8'h17;
	localparam logic [7:0] ID_WARM  = 8'h1A;
	localparam logic [7:0] ID_GOAL  = 8'h04;
	localparam logic [7:0] ID_SLEEP = 8'h16;
	localparam logic [7:0] ID_TEMP  = 8'h0A;
	localparam logic [7:0] ID_HUM   = 8'h0E;
	localparam logic [7:0] TY_BOOL  = 8'h01;
	localparam logic [7:0] TY_VALUE = 8'h02;
	localparam logic [7:0] TY_ENUM  = 8'h04;
	localparam logic [7:0] MIST_NONE = 8'hFF;

	typedef enum logic [4:0] {
		F_HUNT    = 5'b00001,
		F_SYNC    = 5'b00010,
		F_HEAD    = 5'b00100,
		F_PAYLOAD = 5'b01000,
		F_CHECK   = 5'b10000
	} frame_st_t;

	typedef enum logic [4:0] {
		R_ID    = 5'b00001,
		R_TYPE  = 5'b00010,
		R_LENH  = 5'b00100,
		R_LENL  = 5'b01000,
		R_VALUE = 5'b10000
	} rec_st_t;

	frame_st_t   frame_q;
	rec_st_t     rec_q;
	logic [1:0]  hidx_q;
	logic        ver_dp_q;
	logic [15:0] left_q;
	logic        aborted_q;
	logic [7:0]  id_q;
	logic [7:0]  type_q;
	logic [7:0]  len_hi_q;
	logic        len_one_q;
	logic        len_four_q;
	logic [15:0] rem_q;
	logic        first_pend_q;
	logic [7:0]  first_q;
	logic [31:0] accum_q;

	logic [15:0] rec_len;
	logic [15:0] left_m1;
	logic [31:0] accum_nx;
	logic [7:0]  first_nx;
	logic        parse;
	logic        end_zero;
	logic        end_value;
	logic        cls_valid;
	kind_t       cls_kind;
	logic [31:0] cls_value;
	logic        c_one;
	logic        c_four;
	logic [7:0]  c_first;

	assign rec_len  = {len_hi_q, rx_byte};
	assign left_m1  = left_q - 16'd1;
	assign accum_nx = {accum_q[23:0], rx_byte};
	assign first_nx = first_pend_q ? rx_byte : first_q;
	assign parse    = accept && (frame_q == F_PAYLOAD) && ver_dp_q && !aborted_q;

	// record completion: zero-length record or last value byte
	assign end_zero  = parse && (rec_q == R_LENL) && !(rec_len > left_m1) &&
		(rec_len == 16'd0);
	assign end_value = parse && (rec_q == R_VALUE) && (rem_q == 16'd1);

	// operands of the record check; a zero-length record has no value bytes
	assign c_one   = end_value && len_one_q;
	assign c_four  = end_value && len_four_q;
	assign c_first = end_value ? first_nx : 8'h00;

	// per-id type and length check; power takes any type and length
	always_comb begin
		cls_valid = 1'b0;
		cls_kind  = K_POWER;
		cls_value = 32'd0;
		unique case (id_q)
			ID_POWER: begin
				cls_valid = 1'b1;
				cls_kind  = K_POWER;
				cls_value = {31'd0, c_first != 8'h00};
			end
			ID_AUTO: begin
				cls_valid = (type_q == TY_BOOL) && c_one;
				cls_kind  = K_AUTO;
				cls_value = {31'd0, c_first != 8'h00};
			end
			ID_TIMER: begin
				cls_valid = (type_q == TY_ENUM) && c_one;
				cls_kind  = K_TIMER;
				cls_value = {24'd0, c_first};
			end
			ID_MIST: begin
				cls_valid = (type_q == TY_ENUM) && c_one;
				cls_kind  = K_MIST;
				cls_value = {24'd0, (c_first == MIST_NONE) ? 8'h00 : c_first};
			end
			ID_WARM: begin
				cls_valid = (type_q == TY_BOOL) && c_one;
				cls_kind  = K_WARM;
				cls_value = {31'd0, c_first != 8'h00};
			end
			ID_GOAL: begin
				cls_valid = (type_q == TY_ENUM) && c_one;
				cls_kind  = K_GOAL;
				cls_value = {24'd0, c_first};
			end
			ID_SLEEP: begin
				cls_valid = (type_q == TY_BOOL) && c_one;
				cls_kind  = K_SLEEP;
				cls_value = {31'd0, c_first != 8'h00};
			end
			ID_TEMP: begin
				cls_valid = (type_q == TY_VALUE) && c_four;
				cls_kind  = K_TEMP;
				cls_value = accum_nx;
			end
			ID_HUM: begin
				cls_valid = (type_q == TY_VALUE) && c_four;
				cls_kind  = K_HUM;
				cls_value = accum_nx;
			end
			default: begin
				cls_valid = 1'b0;
			end
		endcase
	end

	assign push           = (end_zero || end_value) && cls_valid;
	assign push_cmd.kind  = cls_kind;
	assign push_cmd.value = cls_value;
	assign push_cmd.id    = id_q;

	// frame level sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q   <= F_HUNT;
			hidx_q    <= 2'd0;
			ver_dp_q  <= 1'b0;
			left_q    <= 16'd0;
			aborted_q <= 1'b0;
		end else if (accept) begin
			unique case (frame_q)
				F_HUNT: begin
					if (rx_byte == SYNC0) frame_q <= F_SYNC;
				end
				F_SYNC: begin
					if (rx_byte == SYNC1) begin
						frame_q <= F_HEAD;
						hidx_q  <= 2'd0;
					end else if (rx_byte != SYNC0) begin
						frame_q <= F_HUNT;
					end
				end
				F_HEAD: begin
					hidx_q <= hidx_q + 2'd1;
					case (hidx_q)
						2'd0: ver_dp_q <= (rx_byte == VER_DP);
						2'd2: left_q   <= {rx_byte, 8'h00};
						2'd3: begin
							left_q    <= {left_q[15:8], rx_byte};
							aborted_q <= 1'b0;
							frame_q   <= ({left_q[15:8], rx_byte} != 16'd0) ?
								F_PAYLOAD : F_CHECK;
						end
						default: ;
					endcase
				end
				F_PAYLOAD: begin
					left_q <= left_m1;
					if (left_q == 16'd1) frame_q <= F_CHECK;
					if (parse && (rec_q == R_ID) && (left_q < 16'd4)) aborted_q <= 1'b1;
					if (parse && (rec_q == R_LENL) && (rec_len > left_m1)) aborted_q <= 1'b1;
				end
				F_CHECK: begin
					frame_q <= F_HUNT;
				end
				default: begin
					frame_q <= F_HUNT;
				end
			endcase
		end
	end

	// record level sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q        <= R_ID;
			first_pend_q <= 1'b0;
		end else if (accept && (frame_q == F_HEAD) && (hidx_q == 2'd3)) begin
			rec_q <= R_ID;
		end else if (parse) begin
			unique case (rec_q)
				R_ID: begin
					if (left_q >= 16'd4) rec_q <= R_TYPE;
				end
				R_TYPE: rec_q <= R_LENH;
				R_LENH: rec_q <= R_LENL;
				R_LENL: begin
					first_pend_q <= 1'b1;
					if ((rec_len > left_m1) || (rec_len == 16'd0)) rec_q <= R_ID;
					else rec_q <= R_VALUE;
				end
				R_VALUE: begin
					first_pend_q <= 1'b0;
					if (rem_q == 16'd1) rec_q <= R_ID;
				end
				default: rec_q <= R_ID;
			endcase
		end
	end

	// record fields and value assembly
	always_ff @(posedge clk) begin
		if (parse) begin
			case (rec_q)
				R_ID:   id_q     <= rx_byte;
				R_TYPE: type_q   <= rx_byte;
				R_LENH: len_hi_q <= rx_byte;
				R_LENL: begin
					rem_q      <= rec_len;
					len_one_q  <= (rec_len == 16'd1);
					len_four_q <= (rec_len == 16'd4);
				end
				R_VALUE: begin
					rem_q   <= rem_q - 16'd1;
					accum_q <= accum_nx;
					first_q <= first_nx;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/dfsd_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// dfsd_cmd_fifo
// short command queue between the frame parser and the register bank,
// head entry visible without a read cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "datapoint_frame_status_decoder_macros.svh"

module dfsd_cmd_fifo import dfsd_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head_cmd,
	output q_stat_t stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head_cmd      = entry_q[rd_ptr_q];
	assign stat.full     = (count_q == CNT_FULL);
	assign stat.nonempty = (count_q != '0);

	// entry storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_ONE;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_ONE;
			if (push && !pop)      count_q <= count_q + CNT_ONE;
			else if (pop && !push) count_q <= count_q - CNT_ONE;
		end
	end

	`DFSD_ASSERT(a_count_bound, count_q <= CNT_FULL, "queue fill count beyond depth")
	`DFSD_NEVER(a_no_overflow, push && stat.full, "push into a full queue")
	`DFSD_NEVER(a_no_underflow, pop && !stat.nonempty, "pop from an empty queue")

endmodule

// ===== hw/rtl/dfsd_back.sv =====
// ----------------------------------------------------------------------------
// dfsd_back
// status register bank: applies queued commands and registers a snapshot
// transaction whenever a status value changes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "datapoint_frame_status_decoder_macros.svh"

module dfsd_back import dfsd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             head_cmd,
	input  q_stat_t          stat,
	output logic             pop,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata
);

	logic        power_q;
	logic        auto_q;
	logic        warm_q;
	logic        sleep_q;
	logic [7:0]  timer_q;
	logic [7:0]  mist_q;
	logic [7:0]  goal_q;
	logic [31:0] temp_q;
	logic [31:0] hum_q;
	logic        valid_q;
	logic [OUT_W-1:0] data_q;

	logic        power_nx;
	logic        auto_nx;
	logic        warm_nx;
	logic        sleep_nx;
	logic [7:0]  timer_nx;
	logic [7:0]  mist_nx;
	logic [7:0]  goal_nx;
	logic [31:0] temp_nx;
	logic [31:0] hum_nx;
	logic        changed;

	// output slot free when empty or being taken
	assign pop = stat.nonempty && (!valid_q || m_axis_tready);

	// next register values and change detection
	always_comb begin
		power_nx = power_q;
		auto_nx  = auto_q;
		warm_nx  = warm_q;
		sleep_nx = sleep_q;
		timer_nx = timer_q;
		mist_nx  = mist_q;
		goal_nx  = goal_q;
		temp_nx  = temp_q;
		hum_nx   = hum_q;
		unique case (head_cmd.kind)
			K_POWER: power_nx = head_cmd.value[0];
			K_AUTO:  auto_nx  = head_cmd.value[0];
			K_TIMER: timer_nx = head_cmd.value[7:0];
			K_MIST:  mist_nx  = head_cmd.value[7:0];
			K_WARM:  warm_nx  = head_cmd.value[0];
			K_GOAL:  goal_nx  = head_cmd.value[7:0];
			K_SLEEP: sleep_nx = head_cmd.value[0];
			K_TEMP:  temp_nx  = head_cmd.value;
			K_HUM:   hum_nx   = head_cmd.value;
			default: ;
		endcase
		changed = (power_nx != power_q) || (auto_nx != auto_q) ||
			(warm_nx != warm_q) || (sleep_nx != sleep_q) ||
			(timer_nx != timer_q) || (mist_nx != mist_q) ||
			(goal_nx != goal_q) || (temp_nx != temp_q) || (hum_nx != hum_q);
	end

	// status registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q <= 1'b0;
			auto_q  <= 1'b0;
			warm_q  <= 1'b0;
			sleep_q <= 1'b0;
			timer_q <= 8'h00;
			mist_q  <= 8'h00;
			goal_q  <= 8'h00;
			temp_q  <= 32'd0;
			hum_q   <= 32'd0;
		end else if (pop) begin
			power_q <= power_nx;
			auto_q  <= auto_nx;
			warm_q  <= warm_nx;
			sleep_q <= sleep_nx;
			timer_q <= timer_nx;
			mist_q  <= mist_nx;
			goal_q  <= goal_nx;
			temp_q  <= temp_nx;
			hum_q   <= hum_nx;
		end
	end

	// output transaction valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop && changed) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	// snapshot payload
	always_ff @(posedge clk) begin
		if (pop && changed) begin
			data_q <= {4'b0000, head_cmd.id, hum_nx, temp_nx, sleep_nx, goal_nx, warm_nx,
				mist_nx, timer_nx, auto_nx, power_nx};
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;

	`DFSD_NEVER(a_pop_slot_free, pop && valid_q && !m_axis_tready,
		"command applied while snapshot stalled")
	`DFSD_ASSERT(a_temp_written, (pop && (head_cmd.kind == K_TEMP)) |=>
		(temp_q == $past(head_cmd.value)), "temperature command not applied")
	`DFSD_ASSERT(a_valid_cause, $rose(valid_q) |-> $past(pop),
		"snapshot raised without an applied command")

endmodule

// ===== hw/rtl/datapoint_frame_status_decoder.sv =====
// A record's command is queued, then registered as a snapshot; a stall holds it queued.
// Throughput: one received byte per cycle, at most one snapshot per byte.
// s_axis_tready drops only while the command queue is full, i.e. the output is stalled.
// The queue depth (QUEUE_DEPTH commands) sets how long a stall the parser can absorb.
// Reset (arst_n low, asynchronous): header hunt restarts, all status values read zero.
// ----------------------------------------------------------------------------
// datapoint_frame_status_decoder
// parses 0x55 0xAA framed serial datapoint traffic and reports status
// snapshots whenever a datapoint changes a status register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module datapoint_frame_status_decoder import dfsd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,  // rx_byte
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// power_on, auto_on, timer_value[7:0], mist_setting[7:0], warm_on,
	// humidity_goal[7:0], sleep_on, temperature_value[31:0],
	// humidity_value[31:0], changed_point[7:0], zero pad
	output logic [OUT_W-1:0] m_axis_tdata
);

	logic    accept;
	logic    push;
	cmd_t    push_cmd;
	logic    pop;
	cmd_t    head_cmd;
	q_stat_t stat;

	// input transaction taken whenever the queue can hold its command
	assign s_axis_tready = !stat.full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	dfsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (s_axis_tdata),
		.push     (push),
		.push_cmd (push_cmd)
	);

	dfsd_cmd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.stat     (stat)
	);

	dfsd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_cmd      (head_cmd),
		.stat          (stat),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== bench/datapoint_frame_status_decoder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datapoint frame status decoder checker
// watches both stream channels, decodes every accepted byte with its own
// frame and record parser, queues the status snapshots it expects and
// compares each snapshot the block sends against the oldest one
// ----------------------------------------------------------------------------

package dfsd_tb_pkg;

	// framing bytes
	localparam logic [7:0] SYNC_A    = 8'h55;
	localparam logic [7:0] SYNC_B    = 8'hAA;
	localparam logic [7:0] VER_DP    = 8'h03;
	localparam logic [7:0] VER_OTHER = 8'h07;

	// datapoint ids
	localparam logic [7:0] DP_POWER = 8'h01;
	localparam logic [7:0] DP_AUTO  = 8'h02;
	localparam logic [7:0] DP_TIMER = 8'h13;
	localparam logic [7:0] DP_MIST  = 8'h17;
	localparam logic [7:0] DP_WARM  = 8'h1A;
	localparam logic [7:0] DP_GOAL  = 8'h04;
	localparam logic [7:0] DP_SLEEP = 8'h16;
	localparam logic [7:0] DP_TEMP  = 8'h0A;
	localparam logic [7:0] DP_HUM   = 8'h0E;

	// datapoint types
	localparam logic [7:0] TY_BOOL  = 8'h01;
	localparam logic [7:0] TY_VALUE = 8'h02;
	localparam logic [7:0] TY_ENUM  = 8'h04;

	// mist code that reads back as zero
	localparam logic [7:0] MIST_UNSET = 8'hFF;

endpackage

module datapoint_frame_status_decoder_checker import dfsd_pkg::*, dfsd_tb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,
	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	input  logic [OUT_W-1:0] m_axis_tdata,
	output int unsigned      errors,
	output int unsigned      pending
);

	typedef enum logic [2:0] {
		FR_HUNT,
		FR_SYNC,
		FR_HEAD,
		FR_PAYLOAD,
		FR_CHECKSUM
	} frame_phase_e;

	typedef enum logic [2:0] {
		REC_ID,
		REC_TYPE,
		REC_LEN_HI,
		REC_LEN_LO,
		REC_VALUE
	} record_phase_e;

	typedef struct packed {
		logic        power;
		logic        auto_flag;
		logic [7:0]  timer;
		logic [7:0]  mist;
		logic        warm;
		logic [7:0]  goal;
		logic        sleep;
		logic [31:0] temp;
		logic [31:0] hum;
		logic [7:0]  point;
	} status_t;

	// parser state
	frame_phase_e  phase;
	logic [2:0]    head_idx;
	logic [7:0]    version;
	logic [15:0]   left;
	record_phase_e rec_phase;
	logic [7:0]    rec_id;
	logic [7:0]    rec_type;
	logic [15:0]   rec_len;
	logic [15:0]   val_count;
	logic [31:0]   val_accum;
	logic [7:0]    first_val;
	logic          aborted;

	// status registers and snapshots still owed by the block
	status_t       st;
	status_t       snapshots_q[$];
	int unsigned   error_count;

	// write the record into its status register, flag a change
	task automatic apply_record(output logic hit);
		logic       one;
		logic       four;
		logic       on;
		logic [7:0] mist_new;
		one = (rec_len == 16'd1);
		four = (rec_len == 16'd4);
		on = (first_val != 8'h00);
		mist_new = (first_val == MIST_UNSET) ? 8'h00 : first_val;
		hit = 1'b0;
		case (rec_id)
			DP_POWER: begin
				hit = (st.power != on);
				st.power = on;
			end
			DP_AUTO: if (rec_type == TY_BOOL && one) begin
				hit = (st.auto_flag != on);
				st.auto_flag = on;
			end
			DP_TIMER: if (rec_type == TY_ENUM && one) begin
				hit = (st.timer != first_val);
				st.timer = first_val;
			end
			DP_MIST: if (rec_type == TY_ENUM && one) begin
				hit = (st.mist != mist_new);
				st.mist = mist_new;
			end
			DP_WARM: if (rec_type == TY_BOOL && one) begin
				hit = (st.warm != on);
				st.warm = on;
			end
			DP_GOAL: if (rec_type == TY_ENUM && one) begin
				hit = (st.goal != first_val);
				st.goal = first_val;
			end
			DP_SLEEP: if (rec_type == TY_BOOL && one) begin
				hit = (st.sleep != on);
				st.sleep = on;
			end
			DP_TEMP: if (rec_type == TY_VALUE && four) begin
				hit = (st.temp != val_accum);
				st.temp = val_accum;
			end
			DP_HUM: if (rec_type == TY_VALUE && four) begin
				hit = (st.hum != val_accum);
				st.hum = val_accum;
			end
			default: ;
		endcase
	endtask

	// one payload byte of a datapoint frame; r counts the bytes left with this one
	task automatic record_byte(input logic [7:0] b, input logic [15:0] r, output logic hit);
		hit = 1'b0;
		case (rec_phase)
			REC_ID: begin
				if (r < 16'd4) begin
					aborted = 1'b1;
				end else begin
					rec_id = b;
					rec_phase = REC_TYPE;
				end
			end
			REC_TYPE: begin
				rec_type = b;
				rec_phase = REC_LEN_HI;
			end
			REC_LEN_HI: begin
				rec_len = {b, 8'h00};
				rec_phase = REC_LEN_LO;
			end
			REC_LEN_LO: begin
				rec_len[7:0] = b;
				val_count = '0;
				val_accum = '0;
				first_val = '0;
				if (rec_len > r - 16'd1) begin
					aborted = 1'b1;
					rec_phase = REC_ID;
				end else if (rec_len == 16'd0) begin
					rec_phase = REC_ID;
					apply_record(hit);
				end else begin
					rec_phase = REC_VALUE;
				end
			end
			default: begin
				if (val_count == 16'd0)
					first_val = b;
				val_accum = {val_accum[23:0], b};
				val_count = val_count + 16'd1;
				if (val_count >= rec_len) begin
					rec_phase = REC_ID;
					apply_record(hit);
				end
			end
		endcase
	endtask

	// one received byte through the frame parser
	task automatic decode_byte(input logic [7:0] b, output logic hit);
		hit = 1'b0;
		case (phase)
			FR_HUNT: if (b == SYNC_A) phase = FR_SYNC;
			FR_SYNC: begin
				if (b == SYNC_B) begin
					phase = FR_HEAD;
					head_idx = '0;
				end else if (b != SYNC_A) begin
					phase = FR_HUNT;
				end
			end
			FR_HEAD: begin
				case (head_idx)
					3'd0: version = b;
					3'd2: left = {b, 8'h00};
					3'd3: begin
						left[7:0] = b;
						rec_phase = REC_ID;
						aborted = 1'b0;
						val_count = '0;
						val_accum = '0;
						first_val = '0;
						phase = (left != 16'd0) ? FR_PAYLOAD : FR_CHECKSUM;
					end
					default: ;
				endcase
				head_idx = head_idx + 3'd1;
			end
			FR_PAYLOAD: begin
				if (version == VER_DP && !aborted)
					record_byte(b, left, hit);
				left = left - 16'd1;
				if (left == 16'd0)
					phase = FR_CHECKSUM;
			end
			default: phase = FR_HUNT;
		endcase
	endtask

	// compare one field of a snapshot
	task automatic check_field(input string tag, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: snapshot %s mismatch: expected %h, actual %h", $time, tag, want, got);
			error_count++;
		end
	endtask

	// predict on accepted bytes, compare accepted snapshots
	always @(posedge clk or negedge arst_n) begin
		status_t want;
		status_t got;
		logic    hit;
		if (!arst_n) begin
			phase = FR_HUNT;
			head_idx = '0;
			version = '0;
			left = '0;
			rec_phase = REC_ID;
			rec_id = '0;
			rec_type = '0;
			rec_len = '0;
			val_count = '0;
			val_accum = '0;
			first_val = '0;
			aborted = 1'b0;
			st = '0;
			snapshots_q.delete();
			error_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata, hit);
				if (hit) begin
					want = st;
					want.point = rec_id;
					snapshots_q.push_back(want);
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.power = m_axis_tdata[0];
				got.auto_flag = m_axis_tdata[1];
				got.timer = m_axis_tdata[9:2];
				got.mist = m_axis_tdata[17:10];
				got.warm = m_axis_tdata[18];
				got.goal = m_axis_tdata[26:19];
				got.sleep = m_axis_tdata[27];
				got.temp = m_axis_tdata[59:28];
				got.hum = m_axis_tdata[91:60];
				got.point = m_axis_tdata[99:92];
				if (snapshots_q.size() == 0) begin
					$display("%0t: unexpected snapshot: expected none, actual %h",
						$time, m_axis_tdata);
					error_count++;
				end else begin
					want = snapshots_q.pop_front();
					check_field("power_on", 32'(want.power), 32'(got.power));
					check_field("auto_on", 32'(want.auto_flag), 32'(got.auto_flag));
					check_field("timer_value", 32'(want.timer), 32'(got.timer));
					check_field("mist_setting", 32'(want.mist), 32'(got.mist));
					check_field("warm_on", 32'(want.warm), 32'(got.warm));
					check_field("humidity_goal", 32'(want.goal), 32'(got.goal));
					check_field("sleep_on", 32'(want.sleep), 32'(got.sleep));
					check_field("temperature_value", want.temp, got.temp);
					check_field("humidity_value", want.hum, got.hum);
					check_field("changed_point", 32'(want.point), 32'(got.point));
					check_field("pad", 32'd0, 32'(m_axis_tdata[OUT_W-1:100]));
				end
			end
			errors <= error_count;
			pending <= snapshots_q.size();
		end
	end

endmodule

// ===== bench/datapoint_frame_status_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datapoint frame status decoder testbench
// feeds framed serial traffic (directed frames, then random well-formed
// frames mixed with broken ones and line noise) under random stalls on both
// sides; the checker beside the block predicts and compares every snapshot
// ----------------------------------------------------------------------------

module datapoint_frame_status_decoder_tb import dfsd_pkg::*, dfsd_tb_pkg::*;;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_valid = 1'b0;
	logic [7:0]       s_data = 8'h00;
	logic             s_ready;
	logic             m_valid;
	logic             m_ready = 1'b0;
	logic [OUT_W-1:0] m_data;
	logic             calm = 1'b0;
	int unsigned      errors;
	int unsigned      pending;

	// payload under construction and bytes sent so far
	logic [7:0]       pay[$];
	int unsigned      sent = 0;
	int unsigned      frames = 0;

	always #5 clk = ~clk;

	datapoint_frame_status_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data)
	);

	datapoint_frame_status_decoder_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.errors        (errors),
		.pending       (pending)
	);

	// snapshot sink with random backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_ready <= 1'b0;
		end else begin
			m_ready <= calm || ($urandom_range(99) >= 36);
		end
	end

	// one byte transaction, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(99) < 36) begin
			s_valid <= 1'b0;
			@(posedge clk);
		end
		s_valid <= 1'b1;
		s_data <= b;
		@(posedge clk);
		while (!s_ready)
			@(posedge clk);
		sent++;
	endtask

	// hold the sender until every predicted snapshot has come out
	task automatic drain();
		s_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// header, payload and checksum around the bytes in pay
	task automatic ship_frame(input logic [7:0] ver, input logic [15:0] decl_len,
			input logic [7:0] csum);
		logic [7:0] b;
		repeat ($urandom_range(0, 2)) begin
			b = 8'($urandom);
			send_byte((b == SYNC_A) ? 8'h00 : b);
		end
		repeat ($urandom_range(1, 3))
			send_byte(SYNC_A);
		send_byte(SYNC_B);
		send_byte(ver);
		send_byte(8'($urandom));
		send_byte(decl_len[15:8]);
		send_byte(decl_len[7:0]);
		foreach (pay[i])
			send_byte(pay[i]);
		send_byte(csum);
		frames++;
	endtask

	// a full record; four-byte values go big-endian, others lead with word[7:0]
	task automatic add_record(input logic [7:0] id, input logic [7:0] kind,
			input logic [15:0] len, input logic [31:0] word);
		pay.push_back(id);
		pay.push_back(kind);
		pay.push_back(len[15:8]);
		pay.push_back(len[7:0]);
		for (int i = 0; i < len; i++) begin
			if (len == 16'd4)
				pay.push_back(8'(word >> (8 * (3 - i))));
			else
				pay.push_back((i == 0) ? word[7:0] : 8'($urandom));
		end
	endtask

	// last record of a frame claiming more bytes than are left
	task automatic add_overrun();
		int unsigned k;
		logic [15:0] len;
		k = $urandom_range(0, 3);
		if ($urandom_range(1) == 0)
			len = 16'(k + 1);
		else
			len = 16'($urandom_range(k + 1, 16'hFFFF));
		pay.push_back(DP_TIMER);
		pay.push_back(TY_ENUM);
		pay.push_back(len[15:8]);
		pay.push_back(len[7:0]);
		repeat (k)
			pay.push_back(8'($urandom));
	endtask

	// record aimed at a random datapoint, sometimes with a bad type or length
	task automatic random_record();
		logic [7:0]  id;
		logic [7:0]  kind;
		logic [15:0] len;
		logic [31:0] word;
		len = 16'd1;
		case ($urandom_range(0, 9))
			0: begin
				id = DP_POWER;
				kind = 8'($urandom);
				len = 16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : 1);
			end
			1: begin id = DP_AUTO; kind = TY_BOOL; end
			2: begin id = DP_TIMER; kind = TY_ENUM; end
			3: begin id = DP_MIST; kind = TY_ENUM; end
			4: begin id = DP_WARM; kind = TY_BOOL; end
			5: begin id = DP_GOAL; kind = TY_ENUM; end
			6: begin id = DP_SLEEP; kind = TY_BOOL; end
			7: begin id = DP_TEMP; kind = TY_VALUE; len = 16'd4; end
			8: begin id = DP_HUM; kind = TY_VALUE; len = 16'd4; end
			default: begin
				id = 8'($urandom);
				kind = 8'($urandom);
				len = 16'($urandom_range(0, 4));
			end
		endcase
		if ($urandom_range(99) < 10)
			kind = 8'($urandom);
		if ($urandom_range(99) < 10)
			len = 16'($urandom_range(0, 5));
		case ($urandom_range(0, 7))
			0: word = 32'h0;
			1: word = 32'h1;
			2: word = 32'hFFFF_FFFF;
			default: word = $urandom;
		endcase
		add_record(id, kind, len, word);
	endtask

	// mostly well-formed datapoint frames, some broken or of another version
	task automatic random_frame();
		int unsigned pick;
		logic [15:0] len;
		logic [7:0]  ver;
		pay = {};
		repeat ($urandom_range(0, 5))
			random_record();
		pick = $urandom_range(99);
		if (pick < 10) begin
			repeat ($urandom_range(1, 3))
				pay.push_back(8'($urandom));
		end else if (pick < 20) begin
			add_overrun();
		end
		len = 16'(pay.size());
		if ($urandom_range(99) < 5)
			len = 16'($urandom_range(0, pay.size() + 2));
		ver = ($urandom_range(99) < 90) ? VER_DP : 8'($urandom);
		ship_frame(ver, len, 8'($urandom));
	endtask

	// stimulus
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// line noise, a 0x55 broken by another byte, a stray 0xAA
		send_byte(8'h00);
		send_byte(SYNC_A);
		send_byte(8'h12);
		send_byte(SYNC_B);

		// datapoint frame touching every register, header bytes as data,
		// a short tail and a 0x55 checksum
		pay = {};
		add_record(DP_POWER, TY_BOOL, 16'd0, 32'h0);
		add_record(DP_POWER, TY_BOOL, 16'd1, 32'h80);
		add_record(DP_TEMP, TY_VALUE, 16'd4, 32'h55AA_55AA);
		add_record(DP_HUM, TY_VALUE, 16'd4, 32'h8000_0000);
		add_record(DP_MIST, TY_ENUM, 16'd1, 32'hFF);
		add_record(DP_TIMER, TY_ENUM, 16'd1, 32'hFF);
		add_record(DP_GOAL, TY_ENUM, 16'd1, 32'h00);
		add_record(DP_AUTO, TY_BOOL, 16'd1, 32'h01);
		add_record(DP_WARM, TY_BOOL, 16'd1, 32'h01);
		add_record(DP_SLEEP, TY_BOOL, 16'd1, 32'hFF);
		add_record(8'h33, TY_BOOL, 16'd1, 32'h01);
		add_record(DP_AUTO, TY_ENUM, 16'd1, 32'h00);
		add_record(DP_TEMP, TY_VALUE, 16'd2, 32'h1);
		pay.push_back(8'h00);
		pay.push_back(8'h00);
		ship_frame(VER_DP, 16'(pay.size()), SYNC_A);

		// another version carries records that must be ignored
		pay = {};
		add_record(DP_TIMER, TY_ENUM, 16'd1, 32'h42);
		repeat (256 - pay.size())
			pay.push_back(8'($urandom));
		ship_frame(VER_OTHER, 16'h0100, 8'h00);

		// overrun on the largest length, later records dropped
		pay = {};
		pay.push_back(DP_MIST);
		pay.push_back(TY_ENUM);
		pay.push_back(8'hFF);
		pay.push_back(8'hFF);
		add_record(DP_POWER, TY_BOOL, 16'd1, 32'h0);
		ship_frame(VER_DP, 16'(pay.size()), 8'h00);

		// empty payload goes straight to the checksum
		pay = {};
		ship_frame(VER_DP, 16'd0, SYNC_B);
		drain();

		// random traffic, with one burst free of stalls and one full drain
		while (sent < 1950) begin
			calm <= (sent >= 700 && sent < 1000);
			if (frames == 40)
				drain();
			random_frame();
		end
		calm <= 1'b0;
		drain();

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dfsd_pkg.sv
hw/rtl/dfsd_front.sv
hw/rtl/dfsd_cmd_fifo.sv
hw/rtl/dfsd_back.sv
hw/rtl/datapoint_frame_status_decoder.sv
bench/datapoint_frame_status_decoder_checker.sv
bench/datapoint_frame_status_decoder_tb.sv
